// File: hw/rtl/gcd_pkg.sv
// Shared constants, types and tables for the great circle distance pipeline.
// No dependencies; every other file of the block imports this package.
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ISQRT_STEPS  = 32;
    localparam int UNIT_FRAC    = 30;
    localparam int XW           = 34;   // CORDIC datapath width, signed

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [30:0] PI_Q29      = 31'd1686629713;
    localparam logic [26:0] RECIP_45    = 27'd95443718;   // ceil(2^32 / 45)
    localparam logic [7:0]  TURN_INT    = 8'd182;         // 8192 = 45 * 182 + 2
    localparam logic [15:0] RADIUS_RESET = 16'd6367;
    localparam logic [25:0] DIST_MAX    = 26'h3FFFFFF;

    localparam logic [31:0] ATAN_TURNS [31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000
    };

    typedef logic signed [XW-1:0] cval_t;

    // Arctangent of 2^-i as a binary angle, widened to the CORDIC width.
    function automatic cval_t atan_at(input int i);
        logic [31:0] a;
        a = (i < 31) ? ATAN_TURNS[i] : 32'd0;
        return cval_t'({{(XW-32){1'b0}}, a});
    endfunction

endpackage

// File: hw/rtl/gcd_angle.sv
// Converts the coordinates into four 32-bit binary angles in three stages.
// Depends on gcd_pkg.
module gcd_angle
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_b,
    input  logic signed [24:0] lon_b,
    output logic               out_vld,
    output logic [31:0]        ang [4]    // half dlat, half dlon, lat_a, lat_b
);

    logic [2:0]  vld_reg;
    logic        sgn_reg  [4];
    logic [25:0] mag_reg  [4];
    logic        sgn2_reg [4];
    logic [33:0] int_reg  [4];
    logic [25:0] frac_reg [4];
    logic [31:0] ang_reg  [4];

    logic signed [25:0] q_next [4];
    logic signed [25:0] dlat, dlon;

    always_comb
    begin
        dlat = 26'(lat_b) - 26'(lat_a);
        dlon = 26'(lon_b) - 26'(lon_a);
        // The differences are halved by a floor shift, giving half dlat and half dlon.
        q_next[0] = dlat >>> 1;
        q_next[1] = dlon >>> 1;
        q_next[2] = 26'(lat_a);
        q_next[3] = 26'(lat_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    // Quotient toward zero of |q| * 65536 / 360 = |q| * 182 + floor(2|q| / 45).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sgn_reg[k]  <= q_next[k][25];
                mag_reg[k]  <= q_next[k][25] ? 26'(-q_next[k]) : 26'(q_next[k]);
                sgn2_reg[k] <= sgn_reg[k];
                int_reg[k]  <= 34'(mag_reg[k]) * 34'(TURN_INT);
                frac_reg[k] <= 26'((54'({mag_reg[k], 1'b0}) * 54'(RECIP_45)) >> 32);
                ang_reg[k]  <= sgn2_reg[k] ? 32'(-(int_reg[k] + 34'(frac_reg[k])))
                                           : 32'(int_reg[k] + 34'(frac_reg[k]));
            end
        end
    end

    assign out_vld = vld_reg[2];
    assign ang     = ang_reg;

endmodule

// File: hw/rtl/gcd_sincos.sv
// Pipelined rotation CORDIC: one register stage per iteration plus a quadrant stage.
// Depends on gcd_pkg.
module gcd_sincos
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [31:0]        ang,
    output logic               out_vld,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic [CORDIC_STEPS:0] vld_reg;
    logic [CORDIC_STEPS:0] flip_reg;
    cval_t x_reg [CORDIC_STEPS+1];
    cval_t y_reg [CORDIC_STEPS+1];
    cval_t z_reg [CORDIC_STEPS+1];

    cval_t z_in, z_fold;
    logic  flip_next;

    always_comb
    begin
        z_in      = cval_t'(signed'(ang));
        z_fold    = z_in;
        flip_next = 1'b0;
        // Fold angles beyond a quarter turn back and negate the result.
        if (z_in > cval_t'(34'sd1 <<< 30))
        begin
            z_fold    = z_in - (cval_t'(1) <<< 31);
            flip_next = 1'b1;
        end
        else if (z_in < -(cval_t'(1) <<< 30))
        begin
            z_fold    = z_in + (cval_t'(1) <<< 31);
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[CORDIC_STEPS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= {flip_reg[CORDIC_STEPS-1:0], flip_next};
            x_reg[0] <= cval_t'({2'b00, CORDIC_GAIN});
            y_reg[0] <= '0;
            z_reg[0] <= z_fold;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        cval_t dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][XW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_at(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_at(i);
                end
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STEPS];
    assign sin_val = 32'(flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS]);
    assign cos_val = 32'(flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS]);

endmodule

// File: hw/rtl/gcd_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on gcd_pkg.
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [60:0] val,
    output logic        out_vld,
    output logic [30:0] root
);

    logic [ISQRT_STEPS:0] vld_reg;
    logic [63:0] v_reg [ISQRT_STEPS+1];
    logic [63:0] r_reg [ISQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ISQRT_STEPS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= 64'(val);
            r_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < ISQRT_STEPS; i++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        assign trial = r_reg[i] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_reg[i] >= trial)
                begin
                    v_reg[i+1] <= v_reg[i] - trial;
                    r_reg[i+1] <= (r_reg[i] >> 1) + BIT;
                end
                else
                begin
                    v_reg[i+1] <= v_reg[i];
                    r_reg[i+1] <= r_reg[i] >> 1;
                end
            end
        end
    end

    assign out_vld = vld_reg[ISQRT_STEPS];
    assign root    = r_reg[ISQRT_STEPS][30:0];

endmodule

// File: hw/rtl/gcd_atan.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a binary angle, clamped at zero.
// Depends on gcd_pkg.
module gcd_atan
    import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [30:0] ys,
    input  logic [30:0] xs,
    output logic        out_vld,
    output logic [31:0] angle
);

    logic [CORDIC_STEPS:0] vld_reg;
    cval_t x_reg [CORDIC_STEPS+1];
    cval_t y_reg [CORDIC_STEPS+1];
    cval_t z_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[CORDIC_STEPS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= cval_t'({3'b000, xs});
            y_reg[0] <= cval_t'({3'b000, ys});
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        cval_t dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_at(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_at(i);
                end
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STEPS];
    assign angle   = z_reg[CORDIC_STEPS][XW-1] ? 32'd0 : z_reg[CORDIC_STEPS][31:0];

endmodule

// File: hw/rtl/great_circle_distance.sv
// Top level of the haversine great circle distance pipeline.
// Depends on gcd_pkg, gcd_angle, gcd_sincos, gcd_isqrt and gcd_atan.
//
//  Channel   Direction  Payload (lowest bit up)
//  s_*       request    lat_a[23:0] lon_a[48:24] lat_b[72:49] lon_b[97:73], zero pad
//  m_*       result     distance[25:0], zero pad
//  cfg_*     write      sphere_radius_km[15:0]
//
// One request enters per cycle while the pipeline advances; its distance passes three
// stages of angle conversion, 25 of sine/cosine CORDIC, three of products, 33 of
// square root, 25 of arctangent CORDIC and three of scaling, output register
// included. Reset clears every valid bit and loads the radius with 6367 km.
// While a result waits on m_tready the whole pipeline holds, so nothing is lost
// or repeated.
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // lat_a, lon_a, lat_b, lon_b, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // distance, zero pad
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data   // sphere_radius_km
);

    // Global pipeline advance: every stage moves when the output register is
    // free or is being emptied this cycle.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [15:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_we)
            radius_reg <= cfg_data;
    end

    // Turn the four coordinates into binary angles.
    logic        ang_vld;
    logic [31:0] ang [4];

    gcd_angle u_angle (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (s_tvalid && adv),
        .lat_a   (signed'(s_tdata[23:0])),
        .lon_a   (signed'(s_tdata[48:24])),
        .lat_b   (signed'(s_tdata[72:49])),
        .lon_b   (signed'(s_tdata[97:73])),
        .out_vld (ang_vld),
        .ang     (ang)
    );

    // Four rotation CORDICs run in lockstep; the valid of the first stands for all.
    logic               trig_vld;
    logic signed [31:0] s_lat, s_lon, c_a, c_b;

    gcd_sincos u_sc_dlat (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(ang_vld), .ang(ang[0]),
        .out_vld(trig_vld), .sin_val(s_lat), .cos_val()
    );
    gcd_sincos u_sc_dlon (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(ang_vld), .ang(ang[1]),
        .out_vld(), .sin_val(s_lon), .cos_val()
    );
    gcd_sincos u_sc_lata (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(ang_vld), .ang(ang[2]),
        .out_vld(), .sin_val(), .cos_val(c_a)
    );
    gcd_sincos u_sc_latb (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(ang_vld), .ang(ang[3]),
        .out_vld(), .sin_val(), .cos_val(c_b)
    );

    // Haversine term a, three product stages, 30 fraction bits (60 at the square roots).
    logic [2:0]         mul_vld_reg;
    cval_t              sl2_reg, so2_reg, cc_reg;
    logic signed [35:0] a_reg;
    logic [60:0]        va_reg, vb_reg;

    logic signed [63:0] p_sl, p_so, p_cc;
    logic signed [67:0] p_a;
    logic signed [35:0] a_next;
    logic [30:0]        a_clamp;

    always_comb
    begin
        p_sl   = s_lat * s_lat;
        p_so   = s_lon * s_lon;
        p_cc   = c_a * c_b;
        p_a    = so2_reg * cc_reg;
        a_next = 36'(sl2_reg) + 36'(p_a >>> UNIT_FRAC);
        // a is held to the unit interval before the square roots.
        if (a_reg[35])
            a_clamp = '0;
        else if (a_reg > 36'sd1073741824)
            a_clamp = 31'd1 << UNIT_FRAC;
        else
            a_clamp = a_reg[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= '0;
        else if (adv)
            mul_vld_reg <= {mul_vld_reg[1:0], trig_vld};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl2_reg <= cval_t'(p_sl >>> UNIT_FRAC);
            so2_reg <= cval_t'(p_so >>> UNIT_FRAC);
            cc_reg  <= cval_t'(p_cc >>> UNIT_FRAC);
            a_reg   <= a_next;
            va_reg  <= {a_clamp, {UNIT_FRAC{1'b0}}};
            vb_reg  <= {(31'd1 << UNIT_FRAC) - a_clamp, {UNIT_FRAC{1'b0}}};
        end
    end

    // sqrt(a) and sqrt(1 - a), then the half central angle by vectoring.
    logic        sq_vld;
    logic [30:0] ra, rb;

    gcd_isqrt u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(mul_vld_reg[2]), .val(va_reg),
        .out_vld(sq_vld), .root(ra)
    );
    gcd_isqrt u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(mul_vld_reg[2]), .val(vb_reg),
        .out_vld(), .root(rb)
    );

    logic        z_vld;
    logic [31:0] z_half;

    gcd_atan u_atan (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(sq_vld), .ys(ra), .xs(rb),
        .out_vld(z_vld), .angle(z_half)
    );

    // Scaling: z * R * PI_Q29 / 2^51 in 1/256 km, rounded half up and saturated.
    logic [1:0]  scl_vld_reg;
    logic [47:0] p_reg;
    logic [58:0] t_reg;
    logic [50:0] u_reg;
    logic        out_vld_reg;
    logic [25:0] dist_reg;

    logic [59:0] d_sum;
    logic [28:0] d_full;

    always_comb
    begin
        d_sum  = 60'(t_reg) + 60'(u_reg >> 20) + (60'd1 << 30);
        d_full = d_sum[59:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            scl_vld_reg <= {scl_vld_reg[0], z_vld};
            out_vld_reg <= scl_vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= 48'(z_half) * 48'(radius_reg);
            t_reg    <= 59'(p_reg[47:20]) * 59'(PI_Q29);
            u_reg    <= 51'(p_reg[19:0]) * 51'(PI_Q29);
            dist_reg <= (d_full > 29'(DIST_MAX)) ? DIST_MAX : d_full[25:0];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, dist_reg};

`ifndef SYNTHESIS
    // A waiting result must hold the whole pipeline, input included.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    // Each arctangent result taken on an advance enters the first scaling stage.
    a_scale_follows_atan: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && z_vld) |=> scl_vld_reg[0])
        else $error("arctangent result lost before scaling");

    // A result stays in place until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(dist_reg)))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/tb_great_circle_distance.sv
`timescale 1ns / 100ps
// Self-checking bench for the great circle distance pipeline: directed rows, radius
// extremes, random pairs; each one checked by a bit-exact predictor. Needs gcd_pkg.
module tb_great_circle_distance;
    import gcd_pkg::*;

    localparam int    LATENCY    = 92;
    localparam int    STALL_MAX  = 20000;
    localparam int    RAND_ITEMS = 730;
    localparam int    DEG        = 65536;
    localparam int    LAT_MAX    = 90 * DEG;
    localparam int    LON_MAX    = 180 * DEG;
    localparam longint UNIT_ONE  = 64'sd1 << UNIT_FRAC;

    // One request: both points in degrees * 65536.
    typedef struct packed {
        logic signed [24:0] lon_b;
        logic signed [23:0] lat_b;
        logic signed [24:0] lon_a;
        logic signed [23:0] lat_a;
    } point_pair_t;

    // Directed row: pair, and a typed distance where it is obvious (-1 means predict).
    typedef struct {
        point_pair_t pair;
        longint      known;
    } pair_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;    // lat_a, lon_a, lat_b, lon_b, zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;    // distance, zero pad
    logic         cfg_we;
    logic [15:0]  cfg_data;   // sphere_radius_km

    great_circle_distance dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Predictor's own copy of the radius register.
    logic [15:0]  radius_km;
    logic [25:0]  pending_dist[$];
    int           mismatches;
    int           stall_cycles;
    bit           timed_out;
    bit           idle_ok;       // random idling on both sides is allowed
    bit           hold_off;      // receiver holds off for a long stretch

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Floor shift right of a signed value.
    function automatic longint floor_shr(input longint v, input int k);
        return v >>> k;
    endfunction

    // Angle in degrees with frac fraction bits, to a 32-bit binary angle.
    function automatic logic [31:0] deg_to_turn(input longint x, input int frac);
        longint q;
        longint t;
        q = (frac <= 16) ? x <<< (16 - frac) : floor_shr(x, frac - 16);
        t = (q <<< 16) / 360;
        return t[31:0];
    endfunction

    // Rotation CORDIC: sine and cosine of a binary angle, 30 fraction bits.
    function automatic void rotate_unit(input logic [31:0] ang, output longint s,
                                        output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(signed'(ang));
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30))
        begin
            z -= 64'sd1 <<< 31;
            flip = 1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z += 64'sd1 <<< 31;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_at(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_at(i));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [25:0] predict_distance(input point_pair_t p);
        longint la, oa, lb, ob;
        longint s_lat, s_lon, c1, c2, nc;
        longint sl2, so2, cc, a, ra, rb, x, y, z, dx, dy;
        logic [63:0] pr, t, u, d;
        la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
        rotate_unit(deg_to_turn(lb - la, 17), s_lat, nc);
        rotate_unit(deg_to_turn(ob - oa, 17), s_lon, nc);
        rotate_unit(deg_to_turn(la, 16), nc, c1);
        rotate_unit(deg_to_turn(lb, 16), nc, c2);
        sl2 = floor_shr(s_lat * s_lat, UNIT_FRAC);
        so2 = floor_shr(s_lon * s_lon, UNIT_FRAC);
        cc  = floor_shr(c1 * c2, UNIT_FRAC);
        a = sl2 + floor_shr(so2 * cc, UNIT_FRAC);
        if (a < 0)
            a = 0;
        if (a > UNIT_ONE)
            a = UNIT_ONE;
        ra = int_sqrt(64'(a) << UNIT_FRAC);
        rb = int_sqrt(64'(UNIT_ONE - a) << UNIT_FRAC);
        // Vectoring CORDIC for the half central angle.
        x = rb; y = ra; z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(atan_at(i));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_at(i));
            end
        end
        if (z < 0)
            z = 0;
        pr = 64'(z) * radius_km;
        t = (pr >> 20) * PI_Q29;
        u = (pr & 64'hFFFFF) * PI_Q29;
        d = (t + (u >> 20) + (64'd1 << 30)) >> 31;
        return (d > DIST_MAX) ? DIST_MAX : d[25:0];
    endfunction

    function automatic point_pair_t make_pair(input longint la, input longint oa,
                                              input longint lb, input longint ob);
        point_pair_t p;
        p.lat_a = la[23:0]; p.lon_a = oa[24:0];
        p.lat_b = lb[23:0]; p.lon_b = ob[24:0];
        return p;
    endfunction

    function automatic longint rand_span(input int lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    // Mostly legal coordinates; now and then any bit pattern, to wrap angles.
    function automatic point_pair_t random_pair();
        point_pair_t p;
        int          mode;
        mode = $urandom_range(9);
        if (mode == 0)
            p = point_pair_t'(98'({$urandom, $urandom, $urandom, $urandom}));
        else if (mode == 1)
        begin
            // Nearby points: tiny differences.
            p = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX), 0, 0);
            p.lat_b = p.lat_a + 24'(rand_span(64));
            p.lon_b = p.lon_a + 25'(rand_span(64));
        end
        else if (mode == 2)
        begin
            // Near antipodes, where the distance peaks.
            p = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX), 0, 0);
            p.lat_b = -p.lat_a + 24'(rand_span(512));
            p.lon_b = (p.lon_a >= 0) ? p.lon_a - 25'(LON_MAX) : p.lon_a + 25'(LON_MAX);
        end
        else
            p = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                          rand_span(LAT_MAX), rand_span(LON_MAX));
        return p;
    endfunction

    // Offers one request; tvalid stays high afterwards so requests can follow
    // back to back, and drops only while idling.
    task automatic send_request(input point_pair_t p, input longint known);
        logic [25:0] exp_d;
        exp_d = predict_distance(p);
        if (known >= 0 && exp_d != known[25:0])
            $display("note: typed distance %0d differs from predicted %0d", known, exp_d);
        if (known >= 0)
            exp_d = known[25:0];
        while (idle_ok && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {6'd0, p};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_dist.push_back(exp_d);
        @(negedge clk);
    endtask

    task automatic drain_then_write(input logic [15:0] r);
        s_tvalid <= 1'b0;
        while (pending_dist.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        cfg_data  <= r;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        radius_km = r;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            m_tready <= !(idle_ok && $urandom_range(99) < 23);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_dist.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance %0d", m_tdata[25:0]);
            end
            else if (m_tdata !== {6'd0, pending_dist[0]})
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance mismatch: expected %0d, got %0d",
                             pending_dist[0], m_tdata);
                void'(pending_dist.pop_front());
            end
            else
                void'(pending_dist.pop_front());
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX && !timed_out)
        begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        pair_row_t rows[$];
        logic [15:0] radii[5];
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_we = 1'b0; cfg_data = 16'd0;
        mismatches = 0; stall_cycles = 0; timed_out = 0;
        idle_ok = 0; hold_off = 0;
        radius_km = RADIUS_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: identical points, poles, date line, extremes, wrap-around.
        rows.push_back('{make_pair(0, 0, 0, 0), 0});
        rows.push_back('{make_pair(LAT_MAX, 0, LAT_MAX, LON_MAX), -1});
        rows.push_back('{make_pair(LAT_MAX, 0, -LAT_MAX, 0), -1});
        rows.push_back('{make_pair(0, -LON_MAX, 0, LON_MAX), -1});
        rows.push_back('{make_pair(0, 0, 0, LON_MAX), -1});
        rows.push_back('{make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX), -1});
        rows.push_back('{make_pair(0, 0, 0, 1), -1});
        rows.push_back('{make_pair(0, 0, 1, 0), -1});
        rows.push_back('{make_pair(51 * DEG, 0, 40 * DEG, -74 * DEG), -1});
        rows.push_back('{make_pair(-8388608, -16777216, -8388608, -16777216), 0});
        rows.push_back('{make_pair(8388607, 16777215, -8388608, -16777216), -1});
        rows.push_back('{make_pair(-8388608, 16777215, 8388607, -16777216), -1});
        rows.push_back('{make_pair(0, 0, 0, 16777215), -1});
        rows.push_back('{make_pair(45 * DEG, 90 * DEG, -45 * DEG, -90 * DEG), -1});
        foreach (rows[i])
            send_request(rows[i].pair, rows[i].known);

        // Radius extremes: smallest, largest (longest distances), then default.
        drain_then_write(16'd1);
        send_request(make_pair(LAT_MAX, 0, -LAT_MAX, 0), -1);
        send_request(make_pair(0, 0, 0, 1), 0);
        drain_then_write(16'hFFFF);
        send_request(make_pair(LAT_MAX, 0, -LAT_MAX, 0), -1);
        send_request(make_pair(0, 0, 0, LON_MAX), -1);
        send_request(make_pair(0, 0, 0, DEG), -1);

        // Random phases under different radii; the receiver holds off once.
        radii = '{RADIUS_RESET, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(65535))};
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_then_write(radii[ph]);
            idle_ok = (ph != 1);
            if (ph == 2)
                hold_off = 1;
            for (int n = 0; n < RAND_ITEMS / 5; n++)
                send_request(random_pair(), -1);
        end
        idle_ok = 1;
        s_tvalid <= 1'b0;

        while (pending_dist.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0 && pending_dist.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_angle.sv
hw/rtl/gcd_sincos.sv
hw/rtl/gcd_isqrt.sv
hw/rtl/gcd_atan.sv
hw/rtl/great_circle_distance.sv
tb/sv/tb_great_circle_distance.sv
